// ----- design/modexp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared default operand width and the sequencer state type of the exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned OPERAND_BITS_DEF = 31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_LAUNCH,
    S_MUL,
    S_OUT
  } modexp_state_e;

endpackage

// ----- design/modexp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation input channel
// Valid/ready channel that carries base, exponent and modulus.
// ----------------------------------------------------------------------------
interface modexp_in_if #(
  parameter int unsigned W = modexp_pkg::OPERAND_BITS_DEF
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] base;
  logic [W-1:0] exponent;
  logic [W-1:0] modulus;

  modport source (output valid, output base, output exponent, output modulus, input ready);
  modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

// ----- design/modexp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation output channel
// Valid/ready channel that carries the residue.
// ----------------------------------------------------------------------------
interface modexp_out_if #(
  parameter int unsigned W = modexp_pkg::OPERAND_BITS_DEF
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] residue;

  modport source (output valid, output residue, input ready);
  modport sink   (input valid, input residue, output ready);
endinterface

// ----- design/modexp_mulmod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved shift-add multiplication that reduces after every multiplier bit,
// scanning the multiplier from its most significant bit, one bit per cycle.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
  parameter int unsigned W = modexp_pkg::OPERAND_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] p_o
);
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  a_q, a_d;
  logic [W-1:0]  b_q, b_d;
  logic [W-1:0]  m_q, m_d;
  logic [W-1:0]  r_q, r_d;
  logic [W+1:0]  t;
  logic [W+2:0]  d1;
  logic [W+2:0]  d2;
  logic [W-1:0]  r_step;

  // The partial result stays below the modulus, so one step stays below three times it.
  assign t  = {1'b0, r_q, 1'b0} + {2'b00, (a_q[W-1] ? b_q : {W{1'b0}})};
  assign d1 = {1'b0, t} - {3'b000, m_q};
  assign d2 = {1'b0, t} - {2'b00, m_q, 1'b0};

  always_comb begin
    if (!d2[W+2]) begin
      r_step = d2[W-1:0];
    end else if (!d1[W+2]) begin
      r_step = d1[W-1:0];
    end else begin
      r_step = t[W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      m_d    = m_i;
      r_d    = '0;
    end else if (busy_q) begin
      a_d   = {a_q[W-2:0], 1'b0};
      r_d   = r_step;
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    m_q <= m_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign p_o    = r_q;

  ap_start_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (b_i < m_i))
    else $error("Multiplicand is not below the modulus at start.");

  ap_partial_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q || done_q) |-> (r_q < m_q))
    else $error("Partial result left the residue range.");

  ap_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_q)
    else $error("Done raised while still busy.");

endmodule

// ----- design/modular_exponentiation_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left binary square-and-multiply built on two bit-serial modular
// multipliers that run the square and the accumulate step side by side.
// ----------------------------------------------------------------------------
// An input transfer loads the operands and starts the base reduction on the
// square multiplier. Each exponent bit then takes a launch state that starts
// both multipliers and a multiply state that waits for them, scanning the
// exponent from its least significant bit until no set bit is left. The result
// then loads the output register. A zero exponent or modulus goes straight to
// the output register. One item is in flight at a time. The next input transfer
// can come in the cycle after the result is loaded, and a full output register
// stalls the sequencer. Reset clears the sequencer and the output valid.
module modular_exponentiation_top #(
  parameter int unsigned OPERAND_BITS = modexp_pkg::OPERAND_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  modexp_in_if.sink           in_i,
  modexp_out_if.source        out_o
);
  import modexp_pkg::*;

  localparam int unsigned W = OPERAND_BITS;

  modexp_state_e state_q, state_d;
  logic [W-1:0]  e_q, m_q, acc_q, sq_q, res_q, out_res_q;
  logic          out_valid_q;
  logic          in_acc, out_acc, out_free;
  logic          start_acc, start_sq;
  logic [W-1:0]  sq_a, sq_b, sq_m;
  logic          done_acc, done_sq;
  logic [W-1:0]  p_acc, p_sq;
  logic          in_ready;
  logic          exp_zero, mod_zero;
  logic [W-1:0]  acc_next;

  assign in_acc   = in_i.valid && in_ready;
  assign out_acc  = out_valid_q && out_o.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign exp_zero = (in_i.exponent == '0);
  assign mod_zero = (in_i.modulus == '0);
  assign acc_next = e_q[0] ? p_acc : acc_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (exp_zero || mod_zero) ? S_OUT : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (done_sq) begin
          state_d = S_LAUNCH;
        end
      end
      S_LAUNCH: state_d = S_MUL;
      S_MUL: begin
        if (done_sq) begin
          state_d = (e_q[W-1:1] == '0) ? S_OUT : S_LAUNCH;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    start_acc = 1'b0;
    start_sq  = 1'b0;
    sq_a      = sq_q;
    sq_b      = sq_q;
    sq_m      = m_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        start_sq = in_i.valid && !exp_zero && !mod_zero;
        sq_a     = in_i.base;
        sq_b     = (in_i.modulus == W'(1)) ? '0 : W'(1);
        sq_m     = in_i.modulus;
      end
      S_LAUNCH: begin
        start_acc = 1'b1;
        start_sq  = 1'b1;
      end
      S_REDUCE, S_MUL, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) begin
      e_q   <= in_i.exponent;
      m_q   <= in_i.modulus;
      acc_q <= W'(1);
      res_q <= exp_zero ? W'(1) : '0;
    end
    if (state_q == S_REDUCE && done_sq) begin
      sq_q <= p_sq;
    end
    if (state_q == S_MUL && done_sq) begin
      acc_q <= acc_next;
      sq_q  <= p_sq;
      e_q   <= {1'b0, e_q[W-1:1]};
      res_q <= acc_next;
    end
    if (state_q == S_OUT && out_free) begin
      out_res_q <= res_q;
    end
  end

  modexp_mulmod #(.W(W)) u_mul_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_acc),
    .a_i     (acc_q),
    .b_i     (sq_q),
    .m_i     (m_q),
    .done_o  (done_acc),
    .p_o     (p_acc)
  );

  modexp_mulmod #(.W(W)) u_mul_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_sq),
    .a_i     (sq_a),
    .b_i     (sq_b),
    .m_i     (sq_m),
    .done_o  (done_sq),
    .p_o     (p_sq)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.residue = out_res_q;

  ap_units_in_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (done_acc == done_sq))
    else $error("Square and accumulate units finished out of step.");

  ap_sq_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAUNCH || state_q == S_MUL) |-> (sq_q < m_q))
    else $error("Running square is not reduced by the modulus.");

  ap_done_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_sq |-> (state_q == S_REDUCE || state_q == S_MUL))
    else $error("Multiplier finished outside a multiply phase.");

  ap_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("Sequencer stayed idle after an input transfer.");

endmodule

// ----- tb/tb_modular_exponentiation_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives operand triples into the exponentiation block and checks every
// residue against a square-and-multiply predictor held in a scoreboard.
// Directed corner operands come first, then random operands under several
// handshake profiles, a long output stall and pauses that drain the block.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_top;

  localparam int unsigned W         = modexp_pkg::OPERAND_BITS_DEF;
  localparam logic [W-1:0] MAX_VAL  = {W{1'b1}};
  localparam int unsigned SETTLE    = 1200;
  localparam int unsigned HOLD_LEN  = 3000;
  localparam int unsigned PHASE_LEN = 70;

  class residue_scoreboard;
    logic [W-1:0] pending[$];
    int errors;
    int operand_count;
    int residue_count;

    function automatic logic [W-1:0] predict_residue(logic [W-1:0] b, logic [W-1:0] e,
                                                     logic [W-1:0] m);
      longint unsigned acc;
      longint unsigned sq;
      longint unsigned rem_e;
      longint unsigned md;
      acc   = 1;
      sq    = b;
      rem_e = e;
      md    = m;
      if (e == '0) return W'(1);
      if (m == '0) return '0;
      for (int i = 0; i < W && rem_e != 0; i++) begin
        if (rem_e[0]) acc = (acc * sq) % md;
        sq    = (sq * sq) % md;
        rem_e = rem_e >> 1;
      end
      return acc[W-1:0];
    endfunction

    function void note_operands(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
      pending = {pending, predict_residue(b, e, m)};
      operand_count++;
    endfunction

    function void check_residue(logic [W-1:0] actual);
      logic [W-1:0] expected;
      residue_count++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected residue, expected none, actual %0d", $time, actual);
        errors++;
      end else begin
        expected = pending.pop_front();
        if (actual !== expected) begin
          $display("%0t: residue mismatch, expected %0d, actual %0d", $time, expected, actual);
          errors++;
        end
      end
    endfunction

    function void check_leftover();
      while (pending.size() != 0) begin
        $display("%0t: missing residue, expected %0d, actual none", $time, pending.pop_front());
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_active;

  residue_scoreboard sb = new();

  modexp_in_if  #(.W(W)) in_if ();
  modexp_out_if #(.W(W)) out_if ();

  modular_exponentiation_top #(
    .OPERAND_BITS(W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_operands(in_if.base, in_if.exponent, in_if.modulus);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_residue(out_if.residue);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_active) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_operands(input logic [W-1:0] b, input logic [W-1:0] e,
                               input logic [W-1:0] m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.base     <= b;
    in_if.exponent <= e;
    in_if.modulus  <= m;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic set_profile(input int idle_pct, input int stall_pct);
    drain_results();
    @(posedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    @(negedge clk);
  endtask

  task automatic hold_output(input int cycles);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_active = 1'b0;
  endtask

  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(5))
      0:       return W'($urandom_range(3));
      1:       return MAX_VAL - W'($urandom_range(2));
      2:       return W'($urandom_range(1000));
      3:       return W'($urandom & ((32'd1 << $urandom_range(1, W)) - 32'd1));
      default: return W'($urandom);
    endcase
  endfunction

  task automatic push_random();
    logic [W-1:0] b;
    logic [W-1:0] e;
    logic [W-1:0] m;
    b = rand_operand();
    e = ($urandom_range(19) == 0) ? '0 : rand_operand();
    m = rand_operand();
    if (m == '0) m = W'(1);
    if ($urandom_range(9) == 0) b = m + W'($urandom_range(3));
    if ($urandom_range(9) == 0) m = W'(32'd1 << $urandom_range(W - 1));
    push_operands(b, e, m);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    set_profile(idle_pct, stall_pct);
    repeat (PHASE_LEN) push_random();
  endtask

  initial begin
    rst_n           = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_active     = 1'b0;
    in_if.valid     = 1'b0;
    in_if.base      = '0;
    in_if.exponent  = '0;
    in_if.modulus   = '0;
    out_if.ready    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Zero exponent yields one even for a modulus of one or zero.
    push_operands(W'(0), W'(0), W'(1));
    push_operands(MAX_VAL, W'(0), W'(1));
    push_operands(W'(7), W'(0), W'(0));
    push_operands(W'(0), W'(0), MAX_VAL);
    // Zero modulus and unit modulus with a nonzero exponent yield zero.
    push_operands(W'(7), W'(3), W'(0));
    push_operands(MAX_VAL, MAX_VAL, W'(0));
    push_operands(W'(7), W'(5), W'(1));
    push_operands(MAX_VAL, MAX_VAL, W'(1));
    push_operands(W'(0), W'(5), W'(13));
    push_operands(W'(1), MAX_VAL, MAX_VAL);
    push_operands(MAX_VAL, MAX_VAL, MAX_VAL);
    push_operands(MAX_VAL, MAX_VAL, MAX_VAL - W'(1));
    push_operands(MAX_VAL - W'(1), W'(1), MAX_VAL);
    push_operands(MAX_VAL - W'(1), W'(2), MAX_VAL);
    push_operands(W'(100), W'(1), W'(7));
    push_operands(W'(2), W'(10), W'(1000));
    push_operands(W'(3), W'(200), W'(1000007));
    push_operands(W'(2), W'(30), MAX_VAL);
    push_operands(MAX_VAL, W'(2), W'(2));
    push_operands(31'h5555_5555, 31'h2AAA_AAAA, 31'h4000_0000);
    push_operands(31'h2AAA_AAAA, 31'h5555_5555, 31'h3FFF_FFFF);

    run_phase(0, 0);
    run_phase(83, 0);
    run_phase(0, 83);
    run_phase(11, 11);

    set_profile(0, 0);
    fork
      hold_output(HOLD_LEN);
      repeat (6) push_random();
    join
    drain_results();

    repeat (SETTLE) @(posedge clk);
    sb.check_leftover();
    $display("Run covered %0d operand transfers and %0d residue transfers over four handshake",
             sb.operand_count, sb.residue_count);
    $display("profiles, a long output stall with a blocked input, and drain pauses.");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/modexp_pkg.sv
design/modexp_in_if.sv
design/modexp_out_if.sv
design/modexp_mulmod.sv
design/modular_exponentiation_top.sv
tb/tb_modular_exponentiation_top.sv
